@@ rtl/core/kdb_pkg.sv @@
// Shared types and constants for the keypad debounce scanner.
package kdb_pkg;

  localparam int KEY_W       = 16;
  localparam int INDEX_W     = 4;
  localparam int THRESH_W    = 8;
  localparam int KEYS_CFG_W  = 5;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 8;

  localparam logic [CFG_INDEX_W-1:0] REG_STABLE_THRESHOLD = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_KEYS_IN_USE      = 1'd1;

  localparam logic [THRESH_W-1:0]   THRESH_RESET = 8'd10;
  localparam logic [KEYS_CFG_W-1:0] KEYS_RESET   = 5'd8;

  typedef enum logic [1:0] {
    STATUS_NONE    = 2'd0,
    STATUS_SINGLE  = 2'd1,
    STATUS_SEVERAL = 2'd2
  } kdb_status_t;

  typedef struct packed {
    logic                step;
    logic [THRESH_W-1:0] threshold;
  } kdb_lane_ctrl_t;

  typedef struct packed {
    logic [KEY_W-1:0]   settled_mask;
    kdb_status_t        key_status;
    logic [INDEX_W-1:0] key_index;
  } kdb_result_t;

endpackage

@@ rtl/core/kdb_in_if.sv @@
// Scan frame channel: valid/ready with the sampled key levels.
interface kdb_in_if;
  logic                      valid;
  logic                      ready;
  logic [kdb_pkg::KEY_W-1:0] key_levels;

  modport source (output valid, output key_levels, input ready);
  modport sink   (input valid, input key_levels, output ready);
endinterface

@@ rtl/core/kdb_out_if.sv @@
// Result channel: valid/ready with settled mask, status and key index.
interface kdb_out_if;
  logic                        valid;
  logic                        ready;
  logic [kdb_pkg::KEY_W-1:0]   settled_mask;
  kdb_pkg::kdb_status_t        key_status;
  logic [kdb_pkg::INDEX_W-1:0] key_index;

  modport source (output valid, output settled_mask, output key_status, output key_index,
                  input ready);
  modport sink   (input valid, input settled_mask, input key_status, input key_index,
                  output ready);
endinterface

@@ rtl/core/kdb_lane.sv @@
// One key lane: last level, unstable flag and saturating stability counter.
module kdb_lane #(
  parameter int COUNTER_BITS = 8
) (
  input  logic                    clk,
  input  logic                    rst,
  input  kdb_pkg::kdb_lane_ctrl_t ctrl,
  input  logic                    enable,
  input  logic                    level,
  output logic                    hit
);

  localparam int CMP_W = (COUNTER_BITS > kdb_pkg::THRESH_W) ? COUNTER_BITS
                                                              : kdb_pkg::THRESH_W;

  logic                    last_level, last_level_next;
  logic                    unstable, unstable_next;
  logic [COUNTER_BITS-1:0] cnt, cnt_next;

  logic                    changed;
  logic                    flag_mid;
  logic [COUNTER_BITS-1:0] cnt_mid;
  logic                    settle;
  logic                    upd;

  assign upd     = ctrl.step & enable;
  assign changed = level ^ last_level;
  assign flag_mid = unstable | changed;

  always_comb begin
    cnt_mid = cnt;
    if (flag_mid) begin
      if (changed) begin
        cnt_mid = '0;
      end else if (cnt != {COUNTER_BITS{1'b1}}) begin
        cnt_mid = cnt + 1'b1;
      end
    end
  end

  assign settle = CMP_W'(cnt_mid) > CMP_W'(ctrl.threshold);
  assign hit    = upd & settle & level;

  always_comb begin
    last_level_next = level;
    unstable_next   = settle ? 1'b0 : flag_mid;
    cnt_next        = settle ? '0 : cnt_mid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_level <= 1'b1;
      unstable   <= 1'b0;
      cnt        <= '0;
    end else if (upd) begin
      last_level <= last_level_next;
      unstable   <= unstable_next;
      cnt        <= cnt_next;
    end
  end

endmodule

@@ rtl/core/kdb_merge.sv @@
// Combines lane hits into status/index and buffers results two deep.
module kdb_merge (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  logic [kdb_pkg::KEY_W-1:0]    mask,
  output logic                         space,
  kdb_out_if.source                    out_ch
);

  kdb_pkg::kdb_result_t res;
  kdb_pkg::kdb_result_t entries [2];
  logic                 wr_ptr;
  logic                 rd_ptr;
  logic [1:0]           count;
  logic                 pop;
  logic                 one_hot;
  logic [kdb_pkg::INDEX_W-1:0] idx_or;

  assign one_hot = (mask != '0) && ((mask & (mask - 1'b1)) == '0);

  // only meaningful when exactly one bit is set
  always_comb begin
    idx_or = '0;
    for (int i = 0; i < kdb_pkg::KEY_W; i++) begin
      if (mask[i]) idx_or = idx_or | kdb_pkg::INDEX_W'(i);
    end
  end

  always_comb begin
    res.settled_mask = mask;
    res.key_index    = '0;
    if (mask == '0) begin
      res.key_status = kdb_pkg::STATUS_NONE;
    end else if (one_hot) begin
      res.key_status = kdb_pkg::STATUS_SINGLE;
      res.key_index  = idx_or;
    end else begin
      res.key_status = kdb_pkg::STATUS_SEVERAL;
    end
  end

  assign space = count != 2'd2;
  assign pop   = out_ch.valid & out_ch.ready;

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  assign out_ch.valid        = count != 2'd0;
  assign out_ch.settled_mask = entries[rd_ptr].settled_mask;
  assign out_ch.key_status   = entries[rd_ptr].key_status;
  assign out_ch.key_index    = entries[rd_ptr].key_index;

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("result buffer overfilled");

  a_single_onehot: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.key_status == kdb_pkg::STATUS_SINGLE
      |-> $onehot(out_ch.settled_mask))
    else $error("single status without exactly one settled key");

  a_index_zero: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.key_status != kdb_pkg::STATUS_SINGLE |-> out_ch.key_index == '0)
    else $error("key index set without single status");

  a_none_empty: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.key_status == kdb_pkg::STATUS_NONE
      |-> out_ch.settled_mask == '0)
    else $error("none status with settled keys");

  a_push_room: assert property (@(posedge clk) disable iff (rst) push |-> space)
    else $error("request taken into a full result buffer");

endmodule

@@ rtl/core/keypad_debounce_scanner_core.sv @@
// Keypad debounce scanner: accepts one scan frame per clock cycle whenever the
// two-entry result buffer has room, and the result for a frame is written into the
// buffer as the frame is taken. All keys are debounced side by side, one lane per key,
// so the rate of one frame per cycle holds for any key count; the lanes' counter
// compare and the mask encoder in the merge stage set the cycle's logic depth.
// A key settles once its stability count exceeds stable_threshold; keys at or above
// keys_in_use keep their state and never show in the result.
module keypad_debounce_scanner_core #(
  parameter int MAX_KEYS     = 16,
  parameter int COUNTER_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  kdb_in_if.sink                              key_in,
  kdb_out_if.source                           result_out,
  input  logic                                cfg_we,
  input  logic [kdb_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [kdb_pkg::CFG_DATA_W-1:0]      cfg_data
);

  logic [kdb_pkg::THRESH_W-1:0]   stable_threshold;
  logic [kdb_pkg::KEYS_CFG_W-1:0] keys_in_use;
  logic                           accept;
  logic                           space;
  logic [kdb_pkg::KEY_W-1:0]      hits;
  kdb_pkg::kdb_lane_ctrl_t        lane_ctrl;

  always_ff @(posedge clk) begin
    if (rst) begin
      stable_threshold <= kdb_pkg::THRESH_RESET;
      keys_in_use      <= kdb_pkg::KEYS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        kdb_pkg::REG_STABLE_THRESHOLD: stable_threshold <= cfg_data[kdb_pkg::THRESH_W-1:0];
        kdb_pkg::REG_KEYS_IN_USE:      keys_in_use <= cfg_data[kdb_pkg::KEYS_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  assign key_in.ready = space;
  assign accept       = key_in.valid & space;

  assign lane_ctrl.step      = accept;
  assign lane_ctrl.threshold = stable_threshold;

  for (genvar i = 0; i < kdb_pkg::KEY_W; i++) begin : g_lane
    if (i < MAX_KEYS) begin : g_used
      kdb_lane #(
        .COUNTER_BITS (COUNTER_BITS)
      ) u_lane (
        .clk    (clk),
        .rst    (rst),
        .ctrl   (lane_ctrl),
        .enable (kdb_pkg::KEYS_CFG_W'(i) < keys_in_use),
        .level  (key_in.key_levels[i]),
        .hit    (hits[i])
      );
    end else begin : g_unused
      assign hits[i] = 1'b0;
    end
  end

  kdb_merge u_merge (
    .clk    (clk),
    .rst    (rst),
    .push   (accept),
    .mask   (hits),
    .space  (space),
    .out_ch (result_out)
  );

endmodule
